>>> rtl/core/srfc_pkg.sv
// Shared definitions for the serial receive flow controller.
// Holds the FIFO geometry, the operation and mode codes, the register
// indexes and the packed result beat layout; depends on nothing.
`timescale 1ns / 1ps

package srfc_pkg;

    localparam int FIFO_DEPTH = 256;
    localparam int ADDR_W     = $clog2(FIFO_DEPTH);
    localparam int COUNT_W    = $clog2(FIFO_DEPTH + 1);
    localparam int MARK_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 32;

    localparam logic [7:0] XON_BYTE  = 8'd17;
    localparam logic [7:0] XOFF_BYTE = 8'd19;

    localparam logic [CFG_IDX_W-1:0] CFG_FLOW_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_MARK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_MARK  = 2'd2;

    localparam logic [MARK_W-1:0] HIGH_MARK_RESET = 9'd192;
    localparam logic [MARK_W-1:0] LOW_MARK_RESET  = 9'd64;

    typedef enum logic [1:0] {
        OP_RX   = 2'd0,
        OP_POP  = 2'd1,
        OP_POLL = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_NONE     = 2'd0,
        MODE_RTS_CTS  = 2'd1,
        MODE_DTR_DSR  = 2'd2,
        MODE_XON_XOFF = 2'd3
    } flow_mode_t;

    // First member sits in the highest bits, so the list runs from the top down.
    typedef struct packed {
        logic               pad;
        logic               overflow;
        logic [COUNT_W-1:0] fill_level;
        logic [7:0]         pop_data;
        logic               pop_valid;
        logic               can_transmit;
        logic               dtr_level;
        logic               rts_level;
        logic [7:0]         ctrl_byte;
        logic               ctrl_valid;
    } result_t;

endpackage

>>> rtl/core/srfc_rx_fifo_mem.sv
// Storage array of the receive FIFO with one write port and one
// registered read port. Uses srfc_pkg for the depth and address width.
`timescale 1ns / 1ps

module srfc_rx_fifo_mem
(
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [srfc_pkg::ADDR_W-1:0] wr_addr,
    input  logic [7:0]                 wr_data,
    input  logic                       rd_en,
    input  logic [srfc_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                 rd_data
);
    import srfc_pkg::*;

    logic [7:0] mem [FIFO_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/serial_receive_flow_control.sv
// Top level of the serial receive flow controller: stream ports, the
// configuration registers, the FIFO pointers, the flow flags and the result pipeline.
// Depends on srfc_pkg and srfc_rx_fifo_mem.
`timescale 1ns / 1ps

// The block takes one beat per clock cycle unless m_tready holds the output,
// and returns exactly one result beat for each via the s1 and output registers;
// the registered read port of the 256-byte receive FIFO memory is read beside
// s1. Flow state is updated at acceptance, so a new beat may enter before earlier
// results leave. Write the mode and the marks only while no beat is in flight.

module serial_receive_flow_control
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // rx_byte [7:0], rx_enabled [8], cts_pin [9], dsr_pin [10], zero [15:11]
    input  logic [srfc_pkg::IN_DATA_W-1:0]  s_tdata,
    // operation [1:0]
    input  logic [srfc_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // ctrl_valid [0], ctrl_byte [8:1], rts_level [9], dtr_level [10],
    // can_transmit [11], pop_valid [12], pop_data [20:13], fill_level [29:21],
    // overflow [30], zero [31]
    output logic [srfc_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [srfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srfc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import srfc_pkg::*;

    flow_mode_t         flow_mode_reg;
    logic [MARK_W-1:0]  high_mark_reg;
    logic [MARK_W-1:0]  low_mark_reg;

    logic [ADDR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [ADDR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] prev_level_reg, prev_level_next;
    logic               stopped_reg, stopped_next;
    logic               paused_reg, paused_next;

    logic               s1_valid_reg;
    result_t            s1_reg, s1_next;
    logic               out_valid_reg;
    result_t            out_reg, out_next;

    logic               in_fire;
    logic               out_load;
    logic               store;
    logic               take;
    logic [7:0]         mem_rd_data;

    op_t                op;
    logic [7:0]         rx_byte;
    logic               rx_enabled;
    logic               cts_pin;
    logic               dsr_pin;

    assign op         = op_t'(s_tuser);
    assign rx_byte    = s_tdata[7:0];
    assign rx_enabled = s_tdata[8];
    assign cts_pin    = s_tdata[9];
    assign dsr_pin    = s_tdata[10];

    assign out_load = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || out_load;
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flow_mode_reg <= MODE_NONE;
            high_mark_reg <= HIGH_MARK_RESET;
            low_mark_reg  <= LOW_MARK_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FLOW_MODE: flow_mode_reg <= flow_mode_t'(cfg_data[1:0]);
                CFG_HIGH_MARK: high_mark_reg <= cfg_data[MARK_W-1:0];
                CFG_LOW_MARK:  low_mark_reg  <= cfg_data[MARK_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        count_next      = count_reg;
        prev_level_next = prev_level_reg;
        stopped_next    = stopped_reg;
        paused_next     = paused_reg;
        store           = 1'b0;
        take            = 1'b0;
        s1_next         = '0;

        if (in_fire)
        begin
            case (op)
                OP_RX:
                begin
                    if (rx_enabled)
                    begin
                        if (flow_mode_reg == MODE_XON_XOFF && rx_byte == XON_BYTE)
                        begin
                            paused_next = 1'b0;
                        end
                        else if (flow_mode_reg == MODE_XON_XOFF && rx_byte == XOFF_BYTE)
                        begin
                            paused_next = 1'b1;
                        end
                        else if (count_reg == COUNT_W'(FIFO_DEPTH))
                        begin
                            s1_next.overflow = 1'b1;
                        end
                        else
                        begin
                            store       = 1'b1;
                            wr_ptr_next = wr_ptr_reg + 1'b1;
                            count_next  = count_reg + 1'b1;
                            if (!stopped_reg && count_reg < high_mark_reg
                                && count_next >= high_mark_reg)
                            begin
                                stopped_next = 1'b1;
                                if (flow_mode_reg == MODE_XON_XOFF)
                                begin
                                    s1_next.ctrl_valid = 1'b1;
                                    s1_next.ctrl_byte  = XOFF_BYTE;
                                end
                            end
                        end
                    end
                end
                OP_POP:
                begin
                    if (count_reg != '0)
                    begin
                        take              = 1'b1;
                        s1_next.pop_valid = 1'b1;
                        rd_ptr_next       = rd_ptr_reg + 1'b1;
                        count_next        = count_reg - 1'b1;
                    end
                end
                OP_POLL:
                begin
                    if (stopped_reg && prev_level_reg > low_mark_reg
                        && count_reg <= low_mark_reg)
                    begin
                        stopped_next = 1'b0;
                        if (flow_mode_reg == MODE_XON_XOFF)
                        begin
                            s1_next.ctrl_valid = 1'b1;
                            s1_next.ctrl_byte  = XON_BYTE;
                        end
                    end
                    prev_level_next = count_reg;
                end
                default: ;
            endcase
        end

        case (flow_mode_reg)
            MODE_RTS_CTS:  s1_next.can_transmit = !cts_pin;
            MODE_DTR_DSR:  s1_next.can_transmit = !dsr_pin;
            MODE_XON_XOFF: s1_next.can_transmit = !paused_next;
            default:       s1_next.can_transmit = 1'b1;
        endcase
        s1_next.rts_level  = (flow_mode_reg == MODE_RTS_CTS) && stopped_next;
        s1_next.dtr_level  = (flow_mode_reg == MODE_DTR_DSR) ? stopped_next : 1'b1;
        s1_next.fill_level = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            count_reg      <= '0;
            prev_level_reg <= '0;
            stopped_reg    <= 1'b0;
            paused_reg     <= 1'b0;
        end
        else
        begin
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            count_reg      <= count_next;
            prev_level_reg <= prev_level_next;
            stopped_reg    <= stopped_next;
            paused_reg     <= paused_next;
        end
    end

    srfc_rx_fifo_mem u_mem
    (
        .clk     (clk),
        .wr_en   (store),
        .wr_addr (wr_ptr_reg),
        .wr_data (rx_byte),
        .rd_en   (take),
        .rd_addr (rd_ptr_reg),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        out_next          = s1_reg;
        out_next.pop_data = s1_reg.pop_valid ? mem_rd_data : 8'd0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_reg <= s1_next;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    // The byte count never exceeds the FIFO depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(FIFO_DEPTH))
        else $error("receive FIFO count beyond depth");

    // The pointer distance always agrees with the byte count.
    assert property (@(posedge clk) disable iff (!rst_n)
        ADDR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[ADDR_W-1:0])
        else $error("receive FIFO pointers disagree with count");

    // A dropped byte is reported only with a full FIFO and no pop.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.overflow) |->
        (out_reg.fill_level == COUNT_W'(FIFO_DEPTH) && !out_reg.pop_valid))
        else $error("overflow reported without a full FIFO");

    // A flow control beat always carries XON or XOFF.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.ctrl_valid) |->
        (out_reg.ctrl_byte == XON_BYTE || out_reg.ctrl_byte == XOFF_BYTE))
        else $error("flow control beat with an unknown byte");

endmodule
